### design/jfhc_pkg.sv
// Shared types and marker constants for the JPEG frame header checker.
`timescale 1ns / 1ps
`default_nettype none

package jfhc_pkg;

    typedef enum logic [3:0] {
        PH_START0,
        PH_START1,
        PH_MARK_FF,
        PH_MARK_CODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_FRAME,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic valid;
        logic accepted;
    } verdict_t;

    localparam logic [7:0] MARKER_PREFIX   = 8'hFF;
    localparam logic [7:0] MARKER_SOI      = 8'hD8;
    localparam logic [7:0] MARKER_EOI      = 8'hD9;
    localparam logic [7:0] MARKER_SOS      = 8'hDA;
    localparam logic [7:0] MARKER_RST0     = 8'hD0;
    localparam logic [7:0] MARKER_RST7     = 8'hD7;
    localparam logic [7:0] MARKER_STUFF    = 8'h00;
    localparam logic [7:0] MARKER_TEM      = 8'h01;
    localparam logic [7:0] MARKER_SOF0     = 8'hC0;
    localparam logic [7:0] MARKER_SOF2     = 8'hC2;
    localparam logic [7:0] MARKER_SOF_LAST = 8'hCF;
    localparam logic [7:0] MARKER_DHT      = 8'hC4;
    localparam logic [7:0] MARKER_JPG      = 8'hC8;
    localparam logic [7:0] MARKER_DAC      = 8'hCC;

    localparam logic [7:0]  FRAME_PRECISION  = 8'd8;
    localparam logic [15:0] FRAME_MIN_LEN    = 16'd8;
    localparam logic [15:0] SEG_MIN_LEN      = 16'd2;
    localparam logic [2:0]  BODY_PRECISION   = 3'd0;
    localparam logic [2:0]  BODY_NCOMP       = 3'd5;
    localparam logic [2:0]  BODY_HEADER_END  = 3'd6;
    localparam logic [7:0]  NCOMP_GRAY       = 8'd1;
    localparam logic [7:0]  NCOMP_COLOR      = 8'd3;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m >= MARKER_SOF0) && (m <= MARKER_SOF_LAST) && (m != MARKER_DHT)
            && (m != MARKER_JPG) && (m != MARKER_DAC);
    endfunction

endpackage

`default_nettype wire

### design/jfhc_parser.sv
// Marker segment walker: parse state registers and the per-byte update.
`timescale 1ns / 1ps
`default_nettype none

module jfhc_parser
    import jfhc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_file,
    output logic            verdict_due,
    output verdict_t        verdict
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] seg_len_reg, seg_len_next;
    logic [15:0] remain_reg, remain_next;
    logic [2:0]  body_idx_reg, body_idx_next;
    logic        frame_seen_reg, frame_seen_next;

    logic        decided;
    logic        decision;
    logic [15:0] remain_dec;
    logic [2:0]  body_idx_inc;
    logic [15:0] ncomp_len;
    logic [15:0] new_len;

    assign remain_dec   = remain_reg - 16'd1;
    assign body_idx_inc = body_idx_reg + 3'd1;
    // 8 + 3n for the component count in this byte
    assign ncomp_len    = FRAME_MIN_LEN + {8'd0, data_byte} + {7'd0, data_byte, 1'b0};
    assign new_len      = {seg_len_reg[7:0], data_byte};

    always_comb begin
        phase_next      = phase_reg;
        marker_next     = marker_reg;
        seg_len_next    = seg_len_reg;
        remain_next     = remain_reg;
        body_idx_next   = body_idx_reg;
        frame_seen_next = frame_seen_reg;
        decided         = 1'b0;
        decision        = 1'b0;

        case (phase_reg)
            PH_START0: begin
                if (data_byte != MARKER_PREFIX) decided = 1'b1;
                else phase_next = PH_START1;
            end
            PH_START1: begin
                if (data_byte != MARKER_SOI) decided = 1'b1;
                else phase_next = PH_MARK_FF;
            end
            PH_MARK_FF: begin
                if (data_byte != MARKER_PREFIX) decided = 1'b1;
                else phase_next = PH_MARK_CODE;
            end
            PH_MARK_CODE: begin
                if (data_byte == MARKER_PREFIX) begin
                    // fill byte, stay
                end else if (data_byte == MARKER_EOI) begin
                    decided = 1'b1;
                end else if (data_byte == MARKER_SOS) begin
                    decided  = 1'b1;
                    decision = frame_seen_reg;
                end else if (data_byte == MARKER_STUFF || data_byte == MARKER_TEM ||
                             (data_byte >= MARKER_RST0 && data_byte <= MARKER_RST7)) begin
                    decided = 1'b1;
                end else if (is_frame_marker(data_byte) &&
                             (frame_seen_reg || data_byte > MARKER_SOF2)) begin
                    decided = 1'b1;
                end else begin
                    marker_next = data_byte;
                    phase_next  = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                seg_len_next = {8'd0, data_byte};
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len_next = new_len;
                if (new_len < SEG_MIN_LEN) begin
                    decided = 1'b1;
                end else if (is_frame_marker(marker_reg) && new_len < FRAME_MIN_LEN) begin
                    decided = 1'b1;
                end else begin
                    remain_next   = new_len - SEG_MIN_LEN;
                    body_idx_next = '0;
                    if (new_len == SEG_MIN_LEN) phase_next = PH_MARK_FF;
                    else if (is_frame_marker(marker_reg)) phase_next = PH_FRAME;
                    else phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                remain_next = remain_dec;
                if (remain_dec == 16'd0) phase_next = PH_MARK_FF;
            end
            PH_FRAME: begin
                if (body_idx_reg == BODY_PRECISION && data_byte != FRAME_PRECISION) begin
                    decided = 1'b1;
                end else if (body_idx_reg == BODY_NCOMP &&
                             ((data_byte != NCOMP_GRAY && data_byte != NCOMP_COLOR) ||
                              seg_len_reg != ncomp_len)) begin
                    decided = 1'b1;
                end else begin
                    if (body_idx_reg == BODY_NCOMP) frame_seen_next = 1'b1;
                    body_idx_next = body_idx_inc;
                    remain_next   = remain_dec;
                    if (remain_dec == 16'd0) phase_next = PH_MARK_FF;
                    else if (body_idx_inc >= BODY_HEADER_END) phase_next = PH_SKIP;
                end
            end
            PH_DONE: begin
                // verdict already out: drop the byte
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        if (decided) phase_next = PH_DONE;

        // the byte in hand will produce a verdict once it is stepped
        verdict_due      = phase_reg != PH_DONE && (decided || end_of_file);
        verdict.valid    = step_en && verdict_due;
        verdict.accepted = decided && decision;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && end_of_file)) begin
            phase_reg      <= PH_START0;
            marker_reg     <= '0;
            seg_len_reg    <= '0;
            remain_reg     <= '0;
            body_idx_reg   <= '0;
            frame_seen_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            marker_reg     <= marker_next;
            seg_len_reg    <= seg_len_next;
            remain_reg     <= remain_next;
            body_idx_reg   <= body_idx_next;
            frame_seen_reg <= frame_seen_next;
        end
    end

    // no verdict once the file has been decided
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> !verdict.valid)
        else $error("verdict after file already decided");

    // a passing verdict needs a frame seen earlier
    assert property (@(posedge aclk) disable iff (!aresetn)
        verdict.valid && verdict.accepted |-> frame_seen_reg)
        else $error("accept without frame");

    // end of file always re-arms the walker
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && end_of_file |=> phase_reg == PH_START0 && !frame_seen_reg)
        else $error("walker not re-armed after end of file");

endmodule

`default_nettype wire

### design/jpeg_frame_header_checker.sv
// JPEG frame header checker top level: input stage, parser, verdict register.
//
// Feed one file a byte per beat on s_data_byte, with s_end_of_file set on the
// last byte. Each file yields exactly one beat on m_accepted: 1 when a
// supported 8-bit baseline, extended or progressive frame header came before
// the first scan, 0 when the file is rejected or ends before a scan.
// Both channels are valid/ready. A byte is held in the input register, and its
// verdict, if any, is registered in the verdict register when the byte steps
// the parser. Throughput is one byte per cycle; the only limit is the
// one-entry verdict register, so a stalled m_ready holds the input stage only
// when a new verdict is waiting to be written.
// Bytes after the verdict are dropped until the end-of-file byte, which
// re-arms the parser for the next file.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to expecting the start-of-image marker.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_frame_header_checker
    import jfhc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_end_of_file,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_accepted
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       out_valid_reg;
    logic       out_accepted_reg;
    logic       advance;
    logic       verdict_due;
    verdict_t   verdict;

    // hold the byte only when it would overwrite a verdict still waiting
    assign advance = in_valid_reg && (!out_valid_reg || m_ready || !verdict_due);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eof_reg  <= s_end_of_file;
        end
    end

    jfhc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .verdict_due (verdict_due),
        .verdict     (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (verdict.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (verdict.valid) out_accepted_reg <= verdict.accepted;
    end

    assign m_valid    = out_valid_reg;
    assign m_accepted = out_accepted_reg;

    // an empty input stage always takes a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // a waiting verdict is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !verdict.valid)
        else $error("parser advanced over a pending verdict");

    // a verdict from the parser shows up on the result channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        verdict.valid |=> m_valid && m_accepted == $past(verdict.accepted))
        else $error("verdict lost");

endmodule

`default_nettype wire
